// ----- hdl/pfrd_pkg.sv -----
// Package with screen geometry, store sizing, codes and mask helpers for the rectangle drawer.
`default_nettype none
package pfrd_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  localparam int STORE_PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int COL_W       = $clog2(SCREEN_WIDTH);
  localparam int ROW_W       = $clog2(SCREEN_HEIGHT);
  localparam int PAGE_W      = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
  localparam int ADDR_W      = PAGE_W + COL_W;
  localparam int MEM_DEPTH   = 1 << ADDR_W;

  typedef enum logic [1:0] {
    FUNC_DRAW  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW,
    ST_DRAIN,
    ST_READ,
    ST_RESP
  } state_e;

  // Bits lo..hi of one page byte set.
  function automatic logic [7:0] range_mask(input logic [2:0] lo, input logic [2:0] hi);
    range_mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
  endfunction

  // Page that holds a row.
  function automatic logic [PAGE_W-1:0] row_page(input logic [ROW_W-1:0] row);
    row_page = PAGE_W'(row >> 3);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/page_framebuffer_rectangle_draw_top.sv -----
// Top level: page framebuffer with rectangle outline draw, byte read and clear commands.
//
// A 1-bit-per-pixel image held in one on-chip memory of page bytes (8 rows per byte, bit 0 at
// the top row). Every request gives exactly one result. After reset the block runs a clearing
// pass over all MEM_DEPTH (1024) store bytes, one per cycle, before it takes its first request;
// a clear request runs the same pass and then answers. A read passes through the ST_READ state;
// a rejected draw or an unused code goes straight to the result. An accepted draw walks the
// touched bytes column by column through one shared read-modify-write unit, one byte per
// cycle on the single memory port pair: interior columns touch the top and bottom page bytes,
// the left and right columns every page between them, at most 2*8 + 2*126 = 268 bytes.
// The block takes a new request while the previous result still waits on the output.
`default_nettype none
module page_framebuffer_rectangle_draw_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // rect_x[7:0], rect_y[15:8], rect_width[23:16], rect_height[31:24], pixel_on[32],
  // read_page[35:33], read_column[42:36], zero fill[47:43]
  input  wire logic [47:0] s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_data[7:0], status[8], zero fill[15:9]
  output      logic [15:0] m_axis_tdata
);

  localparam int COL_W  = pfrd_pkg::COL_W;
  localparam int ROW_W  = pfrd_pkg::ROW_W;
  localparam int PAGE_W = pfrd_pkg::PAGE_W;
  localparam int ADDR_W = pfrd_pkg::ADDR_W;

  // Request fields
  logic [7:0] in_x, in_y, in_w, in_h;
  logic       in_on;
  logic [2:0] in_page;
  logic [6:0] in_col;
  pfrd_pkg::func_e in_func;

  assign in_x    = s_axis_tdata[7:0];
  assign in_y    = s_axis_tdata[15:8];
  assign in_w    = s_axis_tdata[23:16];
  assign in_h    = s_axis_tdata[31:24];
  assign in_on   = s_axis_tdata[32];
  assign in_page = s_axis_tdata[35:33];
  assign in_col  = s_axis_tdata[42:36];
  assign in_func = pfrd_pkg::func_e'(s_axis_tuser);

  pfrd_pkg::state_e state_q, state_d;

  // Draw walker and geometry
  logic [COL_W-1:0]  col_q, col_d, x_q, x_d, right_q, right_d;
  logic [PAGE_W-1:0] page_q, page_d, ptop_q, ptop_d, pbot_q, pbot_d;
  logic [2:0]        ytop_q, ytop_d, ybot_q, ybot_d;
  logic              on_q, on_d;

  // Clearing sweep
  logic [ADDR_W-1:0] clr_q, clr_d;

  // Write-back stage of the read-modify-write unit
  logic              wr_vld_q, wr_vld_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic [7:0]        wr_mask_q, wr_mask_d;

  // Result holding and output register
  logic       rd_ok_q, rd_ok_d;
  logic [7:0] res_data_q, res_data_d;
  logic       res_status_q, res_status_d;
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_status_q, out_status_d;

  // Memory
  logic [7:0]        mem [pfrd_pkg::MEM_DEPTH];
  logic [7:0]        rd_q;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_we;

  // Geometry of the incoming draw
  logic [8:0]       sum_x, sum_y;
  logic             reject;
  logic [COL_W-1:0] right_new;
  logic [ROW_W-1:0] bot_new, top_new;

  assign sum_x  = {1'b0, in_x} + {1'b0, in_w};
  assign sum_y  = {1'b0, in_y} + {1'b0, in_h};
  assign reject = ({1'b0, in_x} >= 9'(pfrd_pkg::SCREEN_WIDTH))
               || ({1'b0, in_y} >= 9'(pfrd_pkg::SCREEN_HEIGHT))
               || (in_w == 8'd0) || (in_h == 8'd0);
  assign right_new = (sum_x > 9'(pfrd_pkg::SCREEN_WIDTH))
                   ? COL_W'(pfrd_pkg::SCREEN_WIDTH - 1) : COL_W'(sum_x - 9'd1);
  assign bot_new   = (sum_y > 9'(pfrd_pkg::SCREEN_HEIGHT))
                   ? ROW_W'(pfrd_pkg::SCREEN_HEIGHT - 1) : ROW_W'(sum_y - 9'd1);
  assign top_new   = ROW_W'(in_y);

  // Walker byte mask
  logic       edge_col;
  logic [7:0] walk_mask;
  logic [2:0] lo_row, hi_row;

  assign edge_col = (col_q == x_q) || (col_q == right_q);
  assign lo_row   = (page_q == ptop_q) ? ytop_q : 3'd0;
  assign hi_row   = (page_q == pbot_q) ? ybot_q : 3'd7;

  always_comb begin
    if (edge_col) begin
      walk_mask = pfrd_pkg::range_mask(lo_row, hi_row);
    end else begin
      walk_mask = ((page_q == ptop_q) ? (8'd1 << ytop_q) : 8'd0)
                | ((page_q == pbot_q) ? (8'd1 << ybot_q) : 8'd0);
    end
  end

  assign s_axis_tready = (state_q == pfrd_pkg::ST_IDLE);

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    page_d       = page_q;
    x_d          = x_q;
    right_d      = right_q;
    ptop_d       = ptop_q;
    pbot_d       = pbot_q;
    ytop_d       = ytop_q;
    ybot_d       = ybot_q;
    on_d         = on_q;
    clr_d        = clr_q;
    wr_vld_d     = 1'b0;
    wr_addr_d    = {page_q, col_q};
    wr_mask_d    = walk_mask;
    rd_ok_d      = rd_ok_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    out_vld_d    = out_vld_q & ~m_axis_tready;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    mem_raddr    = {PAGE_W'(in_page), COL_W'(in_col)};
    mem_we       = 1'b0;
    mem_waddr    = clr_q;
    mem_wdata    = 8'd0;

    case (state_q)
      pfrd_pkg::ST_INIT, pfrd_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = (state_q == pfrd_pkg::ST_INIT) ? pfrd_pkg::ST_IDLE : pfrd_pkg::ST_RESP;
        end
      end
      pfrd_pkg::ST_IDLE: begin
        res_data_d   = 8'd0;
        res_status_d = 1'b0;
        if (s_axis_tvalid) begin
          case (in_func)
            pfrd_pkg::FUNC_DRAW: begin
              if (reject) begin
                res_status_d = 1'b1;
                state_d      = pfrd_pkg::ST_RESP;
              end else begin
                x_d     = COL_W'(in_x);
                col_d   = COL_W'(in_x);
                right_d = right_new;
                ptop_d  = pfrd_pkg::row_page(top_new);
                page_d  = pfrd_pkg::row_page(top_new);
                pbot_d  = pfrd_pkg::row_page(bot_new);
                ytop_d  = top_new[2:0];
                ybot_d  = bot_new[2:0];
                on_d    = in_on;
                state_d = pfrd_pkg::ST_DRAW;
              end
            end
            pfrd_pkg::FUNC_READ: begin
              rd_ok_d = ({2'b0, in_page} < 5'(pfrd_pkg::STORE_PAGES))
                     && ({2'b0, in_col} < 9'(pfrd_pkg::SCREEN_WIDTH));
              state_d = pfrd_pkg::ST_READ;
            end
            pfrd_pkg::FUNC_CLEAR: begin
              clr_d   = '0;
              state_d = pfrd_pkg::ST_CLEAR;
            end
            default: begin
              state_d = pfrd_pkg::ST_RESP;
            end
          endcase
        end
      end
      pfrd_pkg::ST_DRAW: begin
        // Read this byte now, write it back next cycle
        mem_raddr = {page_q, col_q};
        wr_vld_d  = 1'b1;
        if (page_q != pbot_q) begin
          page_d = edge_col ? page_q + 1'b1 : pbot_q;
        end else if (col_q == right_q) begin
          state_d = pfrd_pkg::ST_DRAIN;
        end else begin
          col_d  = col_q + 1'b1;
          page_d = ptop_q;
        end
      end
      pfrd_pkg::ST_DRAIN: begin
        state_d = pfrd_pkg::ST_RESP;
      end
      pfrd_pkg::ST_READ: begin
        res_data_d = rd_ok_q ? rd_q : 8'd0;
        state_d    = pfrd_pkg::ST_RESP;
      end
      pfrd_pkg::ST_RESP: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d    = 1'b1;
          out_data_d   = res_data_q;
          out_status_d = res_status_q;
          state_d      = pfrd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pfrd_pkg::ST_IDLE;
      end
    endcase

    // Write back the modified byte from the previous cycle
    if (wr_vld_q) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_q;
      mem_wdata = on_q ? (rd_q | wr_mask_q) : (rd_q & ~wr_mask_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pfrd_pkg::ST_INIT;
      clr_q     <= '0;
      wr_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      wr_vld_q  <= wr_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q        <= col_d;
    page_q       <= page_d;
    x_q          <= x_d;
    right_q      <= right_d;
    ptop_q       <= ptop_d;
    pbot_q       <= pbot_d;
    ytop_q       <= ytop_d;
    ybot_q       <= ybot_d;
    on_q         <= on_d;
    wr_addr_q    <= wr_addr_d;
    wr_mask_q    <= wr_mask_d;
    rd_ok_q      <= rd_ok_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_status_q, out_data_q};

endmodule
`default_nettype wire

// ----- bench/outline_frame_checker.sv -----
// Checker: watches the request and result channels, predicts each result from its own frame copy, compares.
`timescale 1ns / 1ps
module outline_frame_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  // rect_x[7:0], rect_y[15:8], rect_width[23:16], rect_height[31:24], pixel_on[32],
  // read_page[35:33], read_column[42:36], zero fill[47:43]
  input  wire logic [47:0] in_data_i,
  // func[1:0]
  input  wire logic [1:0]  in_user_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  // read_data[7:0], status[8], zero fill[15:9]
  input  wire logic [15:0] out_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic       status;
    logic [7:0] read_data;
  } frame_result_t;

  logic [7:0] pixel_bytes [pfrd_pkg::STORE_PAGES][pfrd_pkg::SCREEN_WIDTH];
  frame_result_t awaited_results [$];
  int mismatches;
  int request_num;

  function automatic void blank_frame();
    foreach (pixel_bytes[p, c]) pixel_bytes[p][c] = 8'h00;
  endfunction

  function automatic void paint_pixel(int col, int row, logic pix_on);
    if (col < pfrd_pkg::SCREEN_WIDTH && row < pfrd_pkg::SCREEN_HEIGHT) begin
      pixel_bytes[row / 8][col][row % 8] = pix_on;
    end
  endfunction

  // Return 1 when the outline was drawn, 0 when the draw is rejected.
  function automatic logic paint_outline(int x, int y, int w, int h, logic pix_on);
    int right;
    int bottom;
    int i;
    if (x >= pfrd_pkg::SCREEN_WIDTH || y >= pfrd_pkg::SCREEN_HEIGHT || w == 0 || h == 0) begin
      return 1'b0;
    end
    if (x + w > pfrd_pkg::SCREEN_WIDTH) w = pfrd_pkg::SCREEN_WIDTH - x;
    if (y + h > pfrd_pkg::SCREEN_HEIGHT) h = pfrd_pkg::SCREEN_HEIGHT - y;
    right  = x + w - 1;
    bottom = y + h - 1;
    for (i = x; i <= right; i++) begin
      paint_pixel(i, y, pix_on);
      paint_pixel(i, bottom, pix_on);
    end
    for (i = y; i <= bottom; i++) begin
      paint_pixel(x, i, pix_on);
      paint_pixel(right, i, pix_on);
    end
    return 1'b1;
  endfunction

  function automatic frame_result_t predict_frame_result(pfrd_pkg::func_e func,
                                                         logic [47:0] d);
    frame_result_t r;
    int page;
    int col;
    r    = '0;
    page = int'(d[35:33]);
    col  = int'(d[42:36]);
    case (func)
      pfrd_pkg::FUNC_DRAW: begin
        r.status = ~paint_outline(int'(d[7:0]), int'(d[15:8]), int'(d[23:16]),
                                  int'(d[31:24]), d[32]);
      end
      pfrd_pkg::FUNC_READ: begin
        if (page < pfrd_pkg::STORE_PAGES && col < pfrd_pkg::SCREEN_WIDTH) begin
          r.read_data = pixel_bytes[page][col];
        end
      end
      pfrd_pkg::FUNC_CLEAR: begin
        blank_frame();
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    frame_result_t want;
    frame_result_t seen;
    if (!rst_ni) begin
      blank_frame();
      awaited_results.delete();
      mismatches   = 0;
      request_num  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Take the result first so a request can never match its own acceptance edge.
      if (out_valid_i && out_ready_i) begin
        seen.read_data = out_data_i[7:0];
        seen.status    = out_data_i[8];
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing awaited: read_data %h status %b",
                     $realtime, seen.read_data, seen.status);
          end
        end else begin
          want = awaited_results.pop_front();
          if (want.read_data !== seen.read_data || want.status !== seen.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d: read_data exp %h got %h, status exp %b got %b",
                       $realtime, request_num, want.read_data, seen.read_data,
                       want.status, seen.status);
            end
          end
          request_num++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(predict_frame_result(pfrd_pkg::func_e'(in_user_i),
                                                       in_data_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top: drives rectangle, read and clear requests and reports the verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int RANDOM_ITEMS = 1000;
  localparam int STALL_LIMIT  = 20000;
  localparam int LONG_HOLD    = 2500;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  int  fail_count;
  int  pending;
  bit  rx_hold_req;

  page_framebuffer_rectangle_draw_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  outline_frame_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // All request fields random, fill bits zero.
  function automatic logic [47:0] random_fields();
    logic [47:0] f;
    f        = 48'({$urandom, $urandom});
    f[47:43] = '0;
    return f;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input pfrd_pkg::func_e func, input logic [47:0] fields);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= fields;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_draw(input logic [7:0] x, input logic [7:0] y, input logic [7:0] w,
                           input logic [7:0] h, input logic pix_on);
    logic [47:0] f;
    f        = random_fields();
    f[31:0]  = {h, w, y, x};
    f[32]    = pix_on;
    send_request(pfrd_pkg::FUNC_DRAW, f);
  endtask

  task automatic send_read(input logic [2:0] page, input logic [6:0] col);
    logic [47:0] f;
    f         = random_fields();
    f[35:33]  = page;
    f[42:36]  = col;
    send_request(pfrd_pkg::FUNC_READ, f);
  endtask

  // Receiver: stall on a changing pattern; hold off long once when asked.
  initial begin : receiver
    int mode;
    int left;
    int held;
    m_axis_tready = 1'b0;
    mode = 0;
    left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int n;
    int pick;
    int burst_left;
    int gap;
    logic [7:0] last_x;
    logic [7:0] last_y;
    logic [7:0] x, y, w, h;
    int page;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = pfrd_pkg::FUNC_DRAW;
    rx_hold_req   = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: blank read, clipped full border, corners, rejects, thin lines, clear.
    send_read(3'd0, 7'd0);
    send_draw(8'd0, 8'd0, 8'd255, 8'd255, 1'b1);
    send_read(3'd0, 7'd0);
    send_read(3'd7, 7'd127);
    send_read(3'd0, 7'd64);
    send_draw(8'd127, 8'd63, 8'd1, 8'd1, 1'b0);
    send_read(3'd7, 7'd127);
    send_draw(8'd128, 8'd0, 8'd5, 8'd5, 1'b1);
    send_draw(8'd0, 8'd64, 8'd5, 8'd5, 1'b1);
    send_draw(8'd4, 8'd4, 8'd0, 8'd5, 1'b1);
    send_draw(8'd4, 8'd4, 8'd5, 8'd0, 1'b1);
    send_draw(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_draw(8'd10, 8'd3, 8'd1, 8'd40, 1'b1);
    send_draw(8'd20, 8'd30, 8'd50, 8'd1, 1'b1);
    send_draw(8'd5, 8'd6, 8'd10, 8'd4, 1'b1);
    send_read(3'd1, 7'd10);
    send_read(3'd3, 7'd40);
    send_read(3'd1, 7'd5);
    send_request(pfrd_pkg::FUNC_NOP, 48'h07FF_FFFF_FFFF);
    send_draw(8'd100, 8'd60, 8'd200, 8'd200, 1'b1);
    send_read(3'd7, 7'd127);
    send_draw(8'd0, 8'd0, 8'd128, 8'd64, 1'b0);
    send_read(3'd0, 7'd0);
    send_request(pfrd_pkg::FUNC_CLEAR, random_fields());
    send_read(3'd3, 7'd20);

    last_x     = 8'd20;
    last_y     = 8'd30;
    burst_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) rx_hold_req = 1'b1;
      if (n == 650) begin
        // Let every outstanding result come back before going on.
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (pending != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_request(pfrd_pkg::FUNC_CLEAR, random_fields());
      end else if (pick < 5) begin
        send_request(pfrd_pkg::FUNC_NOP, random_fields());
      end else if (pick < 45) begin
        if ($urandom_range(0, 1)) begin
          page = (last_y + $urandom_range(0, 15)) / 8;
          if (page > 7) page = 7;
          send_read(3'(page), 7'(last_x + $urandom_range(0, 3)));
        end else begin
          send_read(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          x = 8'($urandom_range(0, 127));
          y = 8'($urandom_range(0, 63));
          pick = $urandom_range(0, 99);
          if (pick < 70) begin
            w = 8'($urandom_range(1, 24));
            h = 8'($urandom_range(1, 24));
          end else if (pick < 90) begin
            w = 8'($urandom_range(1, 255));
            h = 8'($urandom_range(1, 255));
          end else begin
            w = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255));
            h = (w != 0) ? 8'd0 : 8'($urandom_range(0, 255));
          end
          last_x = x;
          last_y = y;
        end else begin
          x = 8'($urandom_range(0, 255));
          y = 8'($urandom_range(0, 255));
          w = 8'($urandom_range(0, 255));
          h = 8'($urandom_range(0, 255));
        end
        send_draw(x, y, w, h, $urandom_range(0, 3) != 0);
      end

      // Sender pacing: bursts with gaps, and one stretch with none.
      if (burst_left > 0) begin
        burst_left--;
      end else if (n < 100 || n >= 200) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 9) >= 3) begin
          gap = $urandom_range(1, 12);
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pfrd_pkg.sv
hdl/page_framebuffer_rectangle_draw_top.sv
bench/outline_frame_checker.sv
bench/tb_top.sv
